@@ rtl/gbfp_pkg.sv @@
// Shared types and constants of the binary frame parser.
`timescale 1ns / 1ps
`default_nettype none

package gbfp_pkg;

  // Parser phase, one per byte position of a frame
  typedef enum logic [3:0] {
    PH_SYNC1   = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_CLASS   = 4'd2,
    PH_ID      = 4'd3,
    PH_LEN1    = 4'd4,
    PH_LEN2    = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CKA     = 4'd7,
    PH_CKB     = 4'd8
  } phase_e;

  // Frame framing and message codes
  localparam logic [7:0]  SYNC1_BYTE  = 8'hB5;
  localparam logic [7:0]  SYNC2_BYTE  = 8'h62;
  localparam logic [7:0]  CLASS_NAV   = 8'h01;
  localparam logic [7:0]  ID_NAV_PVT  = 8'h07;
  localparam logic [7:0]  ID_NAV_DOP  = 8'h04;
  localparam logic [15:0] PVT_MIN_LEN = 16'd92;
  localparam logic [15:0] DOP_MIN_LEN = 16'd18;
  localparam logic [7:0]  FIX_TYPE_3D = 8'd3;

  // Payload byte offsets of the decoded fields
  localparam logic [15:0] OFF_YEAR    = 16'd4;
  localparam logic [15:0] OFF_MONTH   = 16'd6;
  localparam logic [15:0] OFF_DAY     = 16'd7;
  localparam logic [15:0] OFF_HOUR    = 16'd8;
  localparam logic [15:0] OFF_MINUTE  = 16'd9;
  localparam logic [15:0] OFF_SECOND  = 16'd10;
  localparam logic [15:0] OFF_HDOP    = 16'd12;
  localparam logic [15:0] OFF_FIXTYPE = 16'd20;
  localparam logic [15:0] OFF_FLAGS   = 16'd21;
  localparam logic [15:0] OFF_NUMSV   = 16'd23;
  localparam logic [15:0] OFF_LON     = 16'd24;
  localparam logic [15:0] OFF_LAT     = 16'd28;
  localparam logic [15:0] OFF_HMSL    = 16'd36;
  localparam logic [15:0] OFF_GSPEED  = 16'd60;
  localparam logic [15:0] OFF_HEADING = 16'd64;

  // Payload byte write, from the frame tracker to the field store
  typedef struct packed {
    logic        we;
    logic [15:0] index;
    logic [7:0]  data;
  } cap_t;

  // Good frame report, valid for one accepted byte
  typedef struct packed {
    logic       valid;
    logic       pvt;
    logic       dop;
    logic [7:0] cls;
    logic [7:0] id;
  } frame_done_t;

  // Stored navigation fields
  typedef struct packed {
    logic [55:0]        utc;
    logic               has_fix;
    logic [7:0]         fix_type;
    logic [7:0]         sat_count;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [31:0] height_mm;
    logic [31:0]        ground_speed;
    logic signed [31:0] heading;
    logic [15:0]        hdop;
  } nav_t;

endpackage

`default_nettype wire

@@ rtl/gnss_binary_frame_parser.sv @@
// Top level of the binary frame parser: stream ports, result register, checks.
//
// Usage: feed received serial bytes on the s_axis channel, one request per byte;
// tdata carries the byte and a clear-fix flag that drops the pending new-fix flag
// before that byte is parsed. Each frame with a good checksum produces one
// result request on m_axis: class and id of the frame plus the stored
// navigation fields after the frame is decoded. Oversized frames, broken sync
// and bad checksums produce nothing.
// Throughput: one byte per cycle while s_axis_tready is high. The result appears in
// the cycle after the second checksum byte is accepted and stays until m_axis_tready is high.
// Stall: while a result waits, bytes keep flowing; only the second checksum byte
// of the next frame is held off (s_axis_tready low) until the result is taken,
// since the single result register is the one place a result can wait.
// Reset: rst_ni low returns to the sync hunt, clears every stored field, the
// new-fix flag and any pending result. No clearing sweep follows reset.
`timescale 1ns / 1ps
`default_nettype none

module gnss_binary_frame_parser #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [15:0]  s_axis_tdata,   // rx_byte[7:0], clear_fix[8], zero[15:9]
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // class_and_id[15:0], fix_ready[16], has_fix[17], fix_type[25:18],
  // sat_count[33:26], utc_packed[89:34], latitude[121:90], longitude[153:122],
  // height_mm[185:154], ground_speed[217:186], heading[249:218],
  // hdop[265:250], zero[271:266]
  output logic [271:0] m_axis_tdata
);

  gbfp_pkg::phase_e      phase;
  gbfp_pkg::cap_t        cap;
  gbfp_pkg::frame_done_t done;
  gbfp_pkg::nav_t        nav;

  logic        in_acc;
  logic        fix_ready_next;
  logic        out_valid_q, out_valid_d;
  logic [15:0] class_id_q;
  logic        fix_ready_q;

  // Stall only the final checksum byte while a result still waits
  assign s_axis_tready = !out_valid_q || m_axis_tready || (phase != gbfp_pkg::PH_CKB);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  gbfp_frame_fsm #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_frame_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .rx_byte_i (s_axis_tdata[7:0]),
    .phase_o   (phase),
    .cap_o     (cap),
    .done_o    (done)
  );

  gbfp_field_store u_field_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .clear_fix_i (s_axis_tdata[8]),
    .cap_i       (cap),
    .done_i      (done),
    .nav_o       (nav),
    .fix_ready_o (fix_ready_next)
  );

  // Load a result on a good frame, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) out_valid_d = 1'b0;
    if (done.valid) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the fields that move on before the result is taken
  always_ff @(posedge clk_i) begin
    if (done.valid) begin
      class_id_q  <= {done.cls, done.id};
      fix_ready_q <= fix_ready_next;
    end
  end

  // Stored fields change only when a new result is loaded
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, nav.hdop, nav.heading, nav.ground_speed, nav.height_mm,
                          nav.longitude, nav.latitude, nav.utc, nav.sat_count,
                          nav.fix_type, nav.has_fix, fix_ready_q, class_id_q};

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> (!out_valid_q || m_axis_tready))
    else $error("good frame while result register is occupied");

  a_stall_only_ckb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (phase == gbfp_pkg::PH_CKB) && out_valid_q)
    else $error("input stalled outside the final checksum byte");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && (phase == gbfp_pkg::PH_CKB)))
    else $error("result raised without an accepted checksum byte");

  a_pvt_sets_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done.valid && done.pvt) |=> fix_ready_q && out_valid_q)
    else $error("decoded PVT frame did not report a new fix");
`endif

endmodule

`default_nettype wire

@@ rtl/gbfp_frame_fsm.sv @@
// Frame tracker: sync hunt, header, length, payload count and Fletcher check.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_frame_fsm #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        accept_i,
  input  wire  [7:0]                 rx_byte_i,
  output gbfp_pkg::phase_e           phase_o,
  output gbfp_pkg::cap_t             cap_o,
  output gbfp_pkg::frame_done_t      done_o
);

  localparam int CW = $clog2(PAYLOAD_BYTES + 1);

  gbfp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       class_q, class_d;
  logic [7:0]       id_q, id_d;
  logic [15:0]      len_q, len_d;
  logic [CW-1:0]    count_q, count_d;
  logic [7:0]       sum_a_q, sum_a_d;
  logic [7:0]       sum_b_q, sum_b_d;

  logic [7:0]    sum_a_n;
  logic [7:0]    sum_b_n;
  logic [15:0]   len_full;
  logic [CW-1:0] count_inc;

  assign sum_a_n   = sum_a_q + rx_byte_i;
  assign sum_b_n   = sum_b_q + sum_a_n;
  assign len_full  = {rx_byte_i, len_q[7:0]};
  assign count_inc = count_q + 1'b1;

  // Advance the phase on each accepted byte
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      case (phase_q)
        gbfp_pkg::PH_SYNC1: begin
          if (rx_byte_i == gbfp_pkg::SYNC1_BYTE) phase_d = gbfp_pkg::PH_SYNC2;
        end
        gbfp_pkg::PH_SYNC2: begin
          phase_d = (rx_byte_i == gbfp_pkg::SYNC2_BYTE) ? gbfp_pkg::PH_CLASS
                                                         : gbfp_pkg::PH_SYNC1;
        end
        gbfp_pkg::PH_CLASS: phase_d = gbfp_pkg::PH_ID;
        gbfp_pkg::PH_ID:    phase_d = gbfp_pkg::PH_LEN1;
        gbfp_pkg::PH_LEN1:  phase_d = gbfp_pkg::PH_LEN2;
        gbfp_pkg::PH_LEN2: begin
          if (len_full > 16'(PAYLOAD_BYTES)) begin
            phase_d = gbfp_pkg::PH_SYNC1;
          end else if (len_full == 16'd0) begin
            phase_d = gbfp_pkg::PH_CKA;
          end else begin
            phase_d = gbfp_pkg::PH_PAYLOAD;
          end
        end
        gbfp_pkg::PH_PAYLOAD: begin
          if (16'(count_inc) >= len_q) phase_d = gbfp_pkg::PH_CKA;
        end
        gbfp_pkg::PH_CKA: begin
          phase_d = (rx_byte_i == sum_a_q) ? gbfp_pkg::PH_CKB : gbfp_pkg::PH_SYNC1;
        end
        gbfp_pkg::PH_CKB: phase_d = gbfp_pkg::PH_SYNC1;
        default:          phase_d = gbfp_pkg::PH_SYNC1;
      endcase
    end
  end

  // Update header fields, count and sums; report payload writes and good frames
  always_comb begin
    class_d      = class_q;
    id_d         = id_q;
    len_d        = len_q;
    count_d      = count_q;
    sum_a_d      = sum_a_q;
    sum_b_d      = sum_b_q;
    cap_o.we     = 1'b0;
    cap_o.index  = 16'(count_q);
    cap_o.data   = rx_byte_i;
    done_o.valid = 1'b0;
    done_o.cls   = class_q;
    done_o.id    = id_q;
    done_o.pvt   = (class_q == gbfp_pkg::CLASS_NAV) && (id_q == gbfp_pkg::ID_NAV_PVT) &&
                   (len_q >= gbfp_pkg::PVT_MIN_LEN);
    done_o.dop   = (class_q == gbfp_pkg::CLASS_NAV) && (id_q == gbfp_pkg::ID_NAV_DOP) &&
                   (len_q >= gbfp_pkg::DOP_MIN_LEN);
    if (accept_i) begin
      case (phase_q)
        gbfp_pkg::PH_SYNC1: begin
          if (rx_byte_i == gbfp_pkg::SYNC1_BYTE) begin
            class_d = '0;
            id_d    = '0;
            len_d   = '0;
            count_d = '0;
            sum_a_d = '0;
            sum_b_d = '0;
          end
        end
        gbfp_pkg::PH_CLASS: begin
          class_d = rx_byte_i;
          sum_a_d = sum_a_n;
          sum_b_d = sum_b_n;
        end
        gbfp_pkg::PH_ID: begin
          id_d    = rx_byte_i;
          sum_a_d = sum_a_n;
          sum_b_d = sum_b_n;
        end
        gbfp_pkg::PH_LEN1: begin
          len_d   = {8'd0, rx_byte_i};
          sum_a_d = sum_a_n;
          sum_b_d = sum_b_n;
        end
        gbfp_pkg::PH_LEN2: begin
          len_d   = len_full;
          count_d = '0;
          sum_a_d = sum_a_n;
          sum_b_d = sum_b_n;
        end
        gbfp_pkg::PH_PAYLOAD: begin
          cap_o.we = 1'b1;
          count_d  = count_inc;
          sum_a_d  = sum_a_n;
          sum_b_d  = sum_b_n;
        end
        gbfp_pkg::PH_CKB: begin
          done_o.valid = (rx_byte_i == sum_b_q);
        end
        default: begin
          // sync check and first checksum byte only move the phase
        end
      endcase
    end
  end

  // Hold parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= gbfp_pkg::PH_SYNC1;
      class_q <= '0;
      id_q    <= '0;
      len_q   <= '0;
      count_q <= '0;
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      phase_q <= phase_d;
      class_q <= class_d;
      id_q    <= id_d;
      len_q   <= len_d;
      count_q <= count_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign phase_o = phase_q;

endmodule

`default_nettype wire

@@ rtl/gbfp_field_store.sv @@
// Field store: captures payload bytes at field offsets, commits on good PVT/DOP frames.
`timescale 1ns / 1ps
`default_nettype none

module gbfp_field_store (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         accept_i,
  input  wire                         clear_fix_i,
  input  gbfp_pkg::cap_t              cap_i,
  input  gbfp_pkg::frame_done_t       done_i,
  output gbfp_pkg::nav_t              nav_o,
  output logic                        fix_ready_o
);

  // Payload bytes of the current frame, taken at their offsets
  logic [15:0] year_q, year_d;
  logic [7:0]  month_q, month_d;
  logic [7:0]  day_q, day_d;
  logic [7:0]  hour_q, hour_d;
  logic [7:0]  minute_q, minute_d;
  logic [7:0]  second_q, second_d;
  logic [15:0] hdop_sh_q, hdop_sh_d;
  logic [7:0]  fix_type_sh_q, fix_type_sh_d;
  logic        fix_ok_sh_q, fix_ok_sh_d;
  logic [7:0]  numsv_q, numsv_d;
  logic [31:0] lon_sh_q, lon_sh_d;
  logic [31:0] lat_sh_q, lat_sh_d;
  logic [31:0] hmsl_sh_q, hmsl_sh_d;
  logic [31:0] gspeed_sh_q, gspeed_sh_d;
  logic [31:0] heading_sh_q, heading_sh_d;

  // Committed fields
  logic [55:0] utc_q;
  logic [7:0]  fix_type_q;
  logic [7:0]  sat_count_q;
  logic        fix_ok_q;
  logic [31:0] lat_q;
  logic [31:0] lon_q;
  logic [31:0] hmsl_q;
  logic [31:0] gspeed_q;
  logic [31:0] heading_q;
  logic [15:0] hdop_q;
  logic        pending_q, pending_d;

  // Pick payload bytes by offset
  always_comb begin
    year_d        = year_q;
    month_d       = month_q;
    day_d         = day_q;
    hour_d        = hour_q;
    minute_d      = minute_q;
    second_d      = second_q;
    hdop_sh_d     = hdop_sh_q;
    fix_type_sh_d = fix_type_sh_q;
    fix_ok_sh_d   = fix_ok_sh_q;
    numsv_d       = numsv_q;
    lon_sh_d      = lon_sh_q;
    lat_sh_d      = lat_sh_q;
    hmsl_sh_d     = hmsl_sh_q;
    gspeed_sh_d   = gspeed_sh_q;
    heading_sh_d  = heading_sh_q;
    if (cap_i.we) begin
      if (cap_i.index == gbfp_pkg::OFF_MONTH)   month_d       = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_DAY)     day_d         = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_HOUR)    hour_d        = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_MINUTE)  minute_d      = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_SECOND)  second_d      = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_FIXTYPE) fix_type_sh_d = cap_i.data;
      if (cap_i.index == gbfp_pkg::OFF_FLAGS)   fix_ok_sh_d   = cap_i.data[0];
      if (cap_i.index == gbfp_pkg::OFF_NUMSV)   numsv_d       = cap_i.data;
      for (int i = 0; i < 2; i++) begin
        if (cap_i.index == gbfp_pkg::OFF_YEAR + 16'(i)) year_d[8*i +: 8]    = cap_i.data;
        if (cap_i.index == gbfp_pkg::OFF_HDOP + 16'(i)) hdop_sh_d[8*i +: 8] = cap_i.data;
      end
      for (int i = 0; i < 4; i++) begin
        if (cap_i.index == gbfp_pkg::OFF_LON + 16'(i))    lon_sh_d[8*i +: 8]    = cap_i.data;
        if (cap_i.index == gbfp_pkg::OFF_LAT + 16'(i))    lat_sh_d[8*i +: 8]    = cap_i.data;
        if (cap_i.index == gbfp_pkg::OFF_HMSL + 16'(i))   hmsl_sh_d[8*i +: 8]   = cap_i.data;
        if (cap_i.index == gbfp_pkg::OFF_GSPEED + 16'(i)) gspeed_sh_d[8*i +: 8] = cap_i.data;
        if (cap_i.index == gbfp_pkg::OFF_HEADING + 16'(i)) begin
          heading_sh_d[8*i +: 8] = cap_i.data;
        end
      end
    end
  end

  // Capture registers need no reset
  always_ff @(posedge clk_i) begin
    year_q        <= year_d;
    month_q       <= month_d;
    day_q         <= day_d;
    hour_q        <= hour_d;
    minute_q      <= minute_d;
    second_q      <= second_d;
    hdop_sh_q     <= hdop_sh_d;
    fix_type_sh_q <= fix_type_sh_d;
    fix_ok_sh_q   <= fix_ok_sh_d;
    numsv_q       <= numsv_d;
    lon_sh_q      <= lon_sh_d;
    lat_sh_q      <= lat_sh_d;
    hmsl_sh_q     <= hmsl_sh_d;
    gspeed_sh_q   <= gspeed_sh_d;
    heading_sh_q  <= heading_sh_d;
  end

  // Drop the new-fix flag on request, raise it on a decoded PVT frame
  always_comb begin
    pending_d = pending_q;
    if (accept_i && clear_fix_i) pending_d = 1'b0;
    if (done_i.valid && done_i.pvt) pending_d = 1'b1;
  end

  // Commit fields of a good NAV-PVT or NAV-DOP frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utc_q       <= '0;
      fix_type_q  <= '0;
      sat_count_q <= '0;
      fix_ok_q    <= 1'b0;
      lat_q       <= '0;
      lon_q       <= '0;
      hmsl_q      <= '0;
      gspeed_q    <= '0;
      heading_q   <= '0;
      hdop_q      <= '0;
      pending_q   <= 1'b0;
    end else begin
      pending_q <= pending_d;
      if (done_i.valid && done_i.pvt) begin
        utc_q       <= {year_q, month_q, day_q, hour_q, minute_q, second_q};
        fix_type_q  <= fix_type_sh_q;
        sat_count_q <= numsv_q;
        fix_ok_q    <= fix_ok_sh_q;
        lat_q       <= lat_sh_q;
        lon_q       <= lon_sh_q;
        hmsl_q      <= hmsl_sh_q;
        gspeed_q    <= gspeed_sh_q;
        heading_q   <= heading_sh_q;
      end else if (done_i.valid && done_i.dop) begin
        hdop_q <= hdop_sh_q;
      end
    end
  end

  assign nav_o.utc          = utc_q;
  assign nav_o.has_fix      = fix_ok_q && (fix_type_q >= gbfp_pkg::FIX_TYPE_3D);
  assign nav_o.fix_type     = fix_type_q;
  assign nav_o.sat_count    = sat_count_q;
  assign nav_o.latitude     = lat_q;
  assign nav_o.longitude    = lon_q;
  assign nav_o.height_mm    = hmsl_q;
  assign nav_o.ground_speed = gspeed_q;
  assign nav_o.heading      = heading_q;
  assign nav_o.hdop         = hdop_q;
  assign fix_ready_o        = pending_d;

endmodule

`default_nettype wire

@@ test/frame_report_checker.sv @@
// Scoreboard for the binary frame parser: decodes the accepted byte stream and checks reports.
`timescale 1ns / 1ps

module frame_report_checker #(
  parameter int PAYLOAD_BYTES = 128
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  input  wire          s_axis_tready,
  input  wire  [15:0]  s_axis_tdata,   // rx_byte[7:0], clear_fix[8], zero[15:9]
  input  wire          m_axis_tvalid,
  input  wire          m_axis_tready,
  // class_and_id[15:0], fix_ready[16], has_fix[17], fix_type[25:18],
  // sat_count[33:26], utc_packed[89:34], latitude[121:90], longitude[153:122],
  // height_mm[185:154], ground_speed[217:186], heading[249:218],
  // hdop[265:250], zero[271:266]
  input  wire  [271:0] m_axis_tdata,
  output int           error_count_o,
  output int           pending_count_o,
  output int           report_count_o
);

  // One result request, laid out as on m_axis_tdata (first member is the top)
  typedef struct packed {
    logic [5:0]         pad;
    logic [15:0]        hdop;
    logic signed [31:0] heading;
    logic [31:0]        ground_speed;
    logic signed [31:0] height_mm;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic [55:0]        utc;
    logic [7:0]         sat_count;
    logic [7:0]         fix_type;
    logic               has_fix;
    logic               fix_ready;
    logic [15:0]        class_and_id;
  } report_t;

  // Frame tracker and field store of the predictor
  gbfp_pkg::phase_e rx_phase;
  logic [7:0]       msg_class;
  logic [7:0]       msg_id;
  logic [15:0]      msg_len;
  logic [15:0]      pay_count;
  logic [7:0]       sum_a_q;
  logic [7:0]       sum_b_q;
  logic [7:0]       pay_mem [PAYLOAD_BYTES];
  gbfp_pkg::nav_t   nav_q;
  logic             fix_pending;
  report_t          report_q [$];

  // Little-endian 32-bit word from the captured payload
  function automatic logic [31:0] pay_word(input int off);
    logic [31:0] w;
    int          i;
    for (i = 0; i < 4; i++) w[8*i +: 8] = pay_mem[off + i];
    return w;
  endfunction

  // Running Fletcher sum over header and payload
  task automatic add_to_sum(input logic [7:0] b);
    sum_a_q = sum_a_q + b;
    sum_b_q = sum_b_q + sum_a_q;
  endtask

  // Update stored fields from a frame that passed its checksum
  task automatic update_nav_store();
    if (msg_class == gbfp_pkg::CLASS_NAV && msg_id == gbfp_pkg::ID_NAV_PVT &&
        msg_len >= gbfp_pkg::PVT_MIN_LEN) begin
      nav_q.utc = {pay_mem[gbfp_pkg::OFF_YEAR + 16'd1], pay_mem[gbfp_pkg::OFF_YEAR],
                   pay_mem[gbfp_pkg::OFF_MONTH], pay_mem[gbfp_pkg::OFF_DAY],
                   pay_mem[gbfp_pkg::OFF_HOUR], pay_mem[gbfp_pkg::OFF_MINUTE],
                   pay_mem[gbfp_pkg::OFF_SECOND]};
      nav_q.fix_type     = pay_mem[gbfp_pkg::OFF_FIXTYPE];
      nav_q.sat_count    = pay_mem[gbfp_pkg::OFF_NUMSV];
      nav_q.has_fix      = pay_mem[gbfp_pkg::OFF_FLAGS][0] &&
                           (pay_mem[gbfp_pkg::OFF_FIXTYPE] >= gbfp_pkg::FIX_TYPE_3D);
      nav_q.latitude     = pay_word(gbfp_pkg::OFF_LAT);
      nav_q.longitude    = pay_word(gbfp_pkg::OFF_LON);
      nav_q.height_mm    = pay_word(gbfp_pkg::OFF_HMSL);
      nav_q.ground_speed = pay_word(gbfp_pkg::OFF_GSPEED);
      nav_q.heading      = pay_word(gbfp_pkg::OFF_HEADING);
      fix_pending        = 1'b1;
    end else if (msg_class == gbfp_pkg::CLASS_NAV && msg_id == gbfp_pkg::ID_NAV_DOP &&
                 msg_len >= gbfp_pkg::DOP_MIN_LEN) begin
      nav_q.hdop = {pay_mem[gbfp_pkg::OFF_HDOP + 16'd1], pay_mem[gbfp_pkg::OFF_HDOP]};
    end
  endtask

  // Queue the report that a good frame must produce
  task automatic queue_report();
    report_t r;
    r.pad          = '0;
    r.hdop         = nav_q.hdop;
    r.heading      = nav_q.heading;
    r.ground_speed = nav_q.ground_speed;
    r.height_mm    = nav_q.height_mm;
    r.longitude    = nav_q.longitude;
    r.latitude     = nav_q.latitude;
    r.utc          = nav_q.utc;
    r.sat_count    = nav_q.sat_count;
    r.fix_type     = nav_q.fix_type;
    r.has_fix      = nav_q.has_fix;
    r.fix_ready    = fix_pending;
    r.class_and_id = {msg_class, msg_id};
    report_q.push_back(r);
  endtask

  // Advance the frame tracker by one accepted byte
  task automatic take_rx_byte(input logic [7:0] b, input logic clr);
    if (clr) fix_pending = 1'b0;
    case (rx_phase)
      gbfp_pkg::PH_SYNC1: begin
        if (b == gbfp_pkg::SYNC1_BYTE) begin
          msg_class = '0;
          msg_id    = '0;
          msg_len   = '0;
          pay_count = '0;
          sum_a_q   = '0;
          sum_b_q   = '0;
          rx_phase  = gbfp_pkg::PH_SYNC2;
        end
      end
      gbfp_pkg::PH_SYNC2: begin
        rx_phase = (b == gbfp_pkg::SYNC2_BYTE) ? gbfp_pkg::PH_CLASS : gbfp_pkg::PH_SYNC1;
      end
      gbfp_pkg::PH_CLASS: begin
        msg_class = b;
        add_to_sum(b);
        rx_phase = gbfp_pkg::PH_ID;
      end
      gbfp_pkg::PH_ID: begin
        msg_id = b;
        add_to_sum(b);
        rx_phase = gbfp_pkg::PH_LEN1;
      end
      gbfp_pkg::PH_LEN1: begin
        msg_len = {8'h00, b};
        add_to_sum(b);
        rx_phase = gbfp_pkg::PH_LEN2;
      end
      gbfp_pkg::PH_LEN2: begin
        msg_len[15:8] = b;
        add_to_sum(b);
        pay_count = '0;
        if (msg_len > PAYLOAD_BYTES) rx_phase = gbfp_pkg::PH_SYNC1;
        else if (msg_len == 16'd0) rx_phase = gbfp_pkg::PH_CKA;
        else rx_phase = gbfp_pkg::PH_PAYLOAD;
      end
      gbfp_pkg::PH_PAYLOAD: begin
        if (pay_count < PAYLOAD_BYTES) pay_mem[pay_count] = b;
        pay_count = pay_count + 16'd1;
        add_to_sum(b);
        if (pay_count >= msg_len) rx_phase = gbfp_pkg::PH_CKA;
      end
      gbfp_pkg::PH_CKA: begin
        rx_phase = (b == sum_a_q) ? gbfp_pkg::PH_CKB : gbfp_pkg::PH_SYNC1;
      end
      gbfp_pkg::PH_CKB: begin
        rx_phase = gbfp_pkg::PH_SYNC1;
        if (b == sum_b_q) begin
          update_nav_store();
          queue_report();
        end
      end
      default: begin
        rx_phase = gbfp_pkg::PH_SYNC1;
      end
    endcase
  endtask

  task automatic match_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count_o++;
    end
  endtask

  // Compare a delivered report with the oldest one due
  task automatic check_report(input report_t got);
    report_t want;
    report_count_o++;
    if (report_q.size() == 0) begin
      $display("%0t: report for class/id %h arrived with none due, expected nothing, actual %h",
               $time, got.class_and_id, got);
      error_count_o++;
    end else begin
      want = report_q.pop_front();
      match_field("class_and_id", want.class_and_id, got.class_and_id);
      match_field("fix_ready", want.fix_ready, got.fix_ready);
      match_field("has_fix", want.has_fix, got.has_fix);
      match_field("fix_type", want.fix_type, got.fix_type);
      match_field("sat_count", want.sat_count, got.sat_count);
      match_field("utc_packed", want.utc, got.utc);
      match_field("latitude", $unsigned(want.latitude), $unsigned(got.latitude));
      match_field("longitude", $unsigned(want.longitude), $unsigned(got.longitude));
      match_field("height_mm", $unsigned(want.height_mm), $unsigned(got.height_mm));
      match_field("ground_speed", want.ground_speed, got.ground_speed);
      match_field("heading", $unsigned(want.heading), $unsigned(got.heading));
      match_field("hdop", want.hdop, got.hdop);
    end
  endtask

  // Watch both channels; predict on each byte request, check each result request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_phase       = gbfp_pkg::PH_SYNC1;
      msg_class      = '0;
      msg_id         = '0;
      msg_len        = '0;
      pay_count      = '0;
      sum_a_q        = '0;
      sum_b_q        = '0;
      nav_q          = '0;
      fix_pending    = 1'b0;
      error_count_o  = 0;
      report_count_o = 0;
      report_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) take_rx_byte(s_axis_tdata[7:0], s_axis_tdata[8]);
      if (m_axis_tvalid && m_axis_tready) check_report(m_axis_tdata);
    end
    pending_count_o = report_q.size();
  end

endmodule

@@ test/testbench.sv @@
// Testbench top: feeds byte frames into the parser, paces the result channel, gives the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int PAYLOAD_BYTES = 128;
  localparam int BYTE_TARGET   = 1600;
  localparam int REPORT_TARGET = 24;
  localparam int HOLD_AFTER    = 12;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_FILL   = -1;

  typedef enum int {
    FLAW_NONE,
    FLAW_CKA,
    FLAW_CKB
  } flaw_e;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic [15:0]  s_axis_tdata  = '0;   // rx_byte[7:0], clear_fix[8], zero[15:9]
  logic         m_axis_tready = 1'b0;
  wire          s_axis_tready;
  wire          m_axis_tvalid;
  wire  [271:0] m_axis_tdata;         // report fields, see the checker

  int         error_count;
  int         pending_count;
  int         report_count;
  logic [7:0] body [$];
  bit         src_burst    = 1'b0;
  bit         sink_steady  = 1'b0;
  bit         hold_off_req = 1'b0;
  bit         hold_done    = 1'b0;
  int         bytes_sent   = 0;
  int         good_frames  = 0;
  int         stall_left   = 0;
  int         cycle_count  = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gnss_binary_frame_parser #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  frame_report_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .error_count_o   (error_count),
    .pending_count_o (pending_count),
    .report_count_o  (report_count)
  );

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic rand_clear();
    return ($urandom_range(0, 19) == 0);
  endfunction

  function automatic void fill_body(input int len, input int value);
    logic [7:0] v;
    body.delete();
    repeat (len) begin
      v = (value < 0) ? 8'($urandom_range(0, 255)) : 8'(value);
      body.push_back(v);
    end
  endfunction

  function automatic void put_word(input int off, input logic [31:0] w);
    int i;
    for (i = 0; i < 4; i++) body[off + i] = w[8*i +: 8];
  endfunction

  // Offer one byte request, idling first at random, and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic clr);
    int gap;
    gap = (src_burst || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, clr, b};
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // Send sync, header, payload from body and checksum; oversized frames stop at the header
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len_field, input flaw_e flaw,
                            input logic clr_last);
    logic [7:0] hdr [4];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    int         i;
    hdr  = '{cls, id, len_field[7:0], len_field[15:8]};
    ck_a = '0;
    ck_b = '0;
    send_byte(gbfp_pkg::SYNC1_BYTE, rand_clear());
    send_byte(gbfp_pkg::SYNC2_BYTE, rand_clear());
    for (i = 0; i < 4; i++) begin
      send_byte(hdr[i], rand_clear());
      ck_a = ck_a + hdr[i];
      ck_b = ck_b + ck_a;
    end
    if (len_field > PAYLOAD_BYTES) return;
    for (i = 0; i < len_field; i++) begin
      send_byte(body[i], rand_clear());
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end
    if (flaw == FLAW_CKA) ck_a = ck_a ^ (8'd1 << $urandom_range(0, 7));
    if (flaw == FLAW_CKB) ck_b = ck_b ^ (8'd1 << $urandom_range(0, 7));
    send_byte(ck_a, rand_clear());
    send_byte(ck_b, clr_last | rand_clear());
    if (flaw == FLAW_NONE) good_frames++;
  endtask

  // Stray bytes while hunting, sometimes a sync pair that breaks
  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 4)) begin
      b = 8'($urandom_range(0, 255));
      if (b == gbfp_pkg::SYNC1_BYTE) b = gbfp_pkg::SYNC2_BYTE;
      send_byte(b, rand_clear());
    end
    if ($urandom_range(0, 2) == 0) begin
      send_byte(gbfp_pkg::SYNC1_BYTE, rand_clear());
      b = 8'($urandom_range(0, 255));
      if (b == gbfp_pkg::SYNC2_BYTE) b = gbfp_pkg::SYNC1_BYTE;
      send_byte(b, rand_clear());
    end
  endtask

  // Pick one random frame: mostly well formed, some broken
  task automatic send_random_frame();
    int    kind;
    int    len;
    flaw_e flaw;
    kind = $urandom_range(0, 99);
    flaw = FLAW_NONE;
    if ($urandom_range(0, 9) == 0) flaw = ($urandom_range(0, 1) != 0) ? FLAW_CKA : FLAW_CKB;
    if (kind < 25) begin
      len = ($urandom_range(0, 7) == 0) ?
            $urandom_range(gbfp_pkg::PVT_MIN_LEN, PAYLOAD_BYTES) :
            $urandom_range(gbfp_pkg::PVT_MIN_LEN - 16'd2, gbfp_pkg::PVT_MIN_LEN + 16'd6);
      fill_body(len, RANDOM_FILL);
      if ($urandom_range(0, 3) != 0) body[gbfp_pkg::OFF_FIXTYPE] = 8'($urandom_range(0, 5));
      send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, 16'(len), flaw, rand_clear());
    end else if (kind < 50) begin
      len = ($urandom_range(0, 7) == 0) ?
            $urandom_range(0, PAYLOAD_BYTES) :
            $urandom_range(gbfp_pkg::DOP_MIN_LEN - 16'd2, gbfp_pkg::DOP_MIN_LEN + 16'd6);
      fill_body(len, RANDOM_FILL);
      send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_DOP, 16'(len), flaw, rand_clear());
    end else if (kind < 80) begin
      len = $urandom_range(0, 12);
      fill_body(len, RANDOM_FILL);
      send_frame(($urandom_range(0, 1) != 0) ? gbfp_pkg::CLASS_NAV : 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 16'(len), flaw, rand_clear());
    end else if (kind < 86) begin
      len = ($urandom_range(0, 1) != 0) ? $urandom_range(PAYLOAD_BYTES + 1, PAYLOAD_BYTES + 12)
                                        : $urandom_range(PAYLOAD_BYTES + 1, 65535);
      body.delete();
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len),
                 FLAW_NONE, 1'b0);
    end else begin
      send_noise();
    end
  endtask

  // Directed cases, then random traffic, then drain and verdict
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty payload before anything is stored
    fill_body(0, 0);
    send_frame(8'h00, 8'h00, 16'd0, FLAW_NONE, 1'b0);
    // stray bytes while hunting are ignored
    send_byte(gbfp_pkg::SYNC2_BYTE, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // good 3D fix at the minimum length
    fill_body(gbfp_pkg::PVT_MIN_LEN, RANDOM_FILL);
    body[gbfp_pkg::OFF_FIXTYPE] = gbfp_pkg::FIX_TYPE_3D;
    body[gbfp_pkg::OFF_FLAGS]   = body[gbfp_pkg::OFF_FLAGS] | 8'h01;
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, gbfp_pkg::PVT_MIN_LEN, FLAW_NONE,
               1'b0);
    // signed extremes, fix flag off
    fill_body(100, 0);
    put_word(gbfp_pkg::OFF_LAT, 32'h8000_0000);
    put_word(gbfp_pkg::OFF_LON, 32'h7FFF_FFFF);
    put_word(gbfp_pkg::OFF_HMSL, 32'h8000_0000);
    put_word(gbfp_pkg::OFF_GSPEED, 32'hFFFF_FFFF);
    put_word(gbfp_pkg::OFF_HEADING, 32'h7FFF_FFFF);
    body[gbfp_pkg::OFF_FIXTYPE] = 8'hFF;
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, 16'd100, FLAW_NONE, 1'b0);
    // largest payload, all ones, fix type just below 3D; clear on the last byte
    fill_body(PAYLOAD_BYTES, 8'hFF);
    body[gbfp_pkg::OFF_FIXTYPE] = gbfp_pkg::FIX_TYPE_3D - 8'd1;
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, 16'(PAYLOAD_BYTES), FLAW_NONE, 1'b1);
    // one byte short of a NAV-PVT decode
    fill_body(gbfp_pkg::PVT_MIN_LEN - 16'd1, RANDOM_FILL);
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, gbfp_pkg::PVT_MIN_LEN - 16'd1,
               FLAW_NONE, 1'b0);
    // drop the new-fix flag on a stray byte, then a minimal NAV-DOP
    send_byte(8'h00, 1'b1);
    fill_body(gbfp_pkg::DOP_MIN_LEN, RANDOM_FILL);
    body[gbfp_pkg::OFF_HDOP]         = 8'hFF;
    body[gbfp_pkg::OFF_HDOP + 16'd1] = 8'hFF;
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_DOP, gbfp_pkg::DOP_MIN_LEN, FLAW_NONE,
               1'b0);
    // NAV-DOP one byte short
    fill_body(gbfp_pkg::DOP_MIN_LEN - 16'd1, 0);
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_DOP, gbfp_pkg::DOP_MIN_LEN - 16'd1,
               FLAW_NONE, 1'b0);
    // oversized frames end at the length
    body.delete();
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_PVT, 16'(PAYLOAD_BYTES + 1), FLAW_NONE,
               1'b0);
    send_frame(8'hFF, 8'hFF, 16'hFFFF, FLAW_NONE, 1'b0);
    // checksum errors on either byte
    fill_body(4, RANDOM_FILL);
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_DOP, 16'd4, FLAW_CKA, 1'b0);
    send_frame(gbfp_pkg::CLASS_NAV, gbfp_pkg::ID_NAV_DOP, 16'd4, FLAW_CKB, 1'b0);
    // broken sync, including a repeated first sync byte
    send_byte(gbfp_pkg::SYNC1_BYTE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(gbfp_pkg::SYNC1_BYTE, 1'b0);
    send_byte(gbfp_pkg::SYNC1_BYTE, 1'b0);
    send_byte(gbfp_pkg::SYNC2_BYTE, 1'b0);
    // recover on a foreign message
    fill_body(1, 8'hA5);
    send_frame(8'hFF, 8'hFF, 16'd1, FLAW_NONE, 1'b0);

    // random traffic; one long result stall part way through
    while (bytes_sent < BYTE_TARGET || good_frames < REPORT_TARGET) begin
      if (good_frames >= HOLD_AFTER && !hold_off_req) hold_off_req <= 1'b1;
      if ($urandom_range(0, 7) == 0) src_burst = !src_burst;
      send_random_frame();
    end
    s_axis_tvalid <= 1'b0;

    // drain outstanding results
    @(posedge clk_i);
    while (pending_count != 0 || m_axis_tvalid) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d bytes: %0d clean frames among short, foreign, oversized,",
             bytes_sent, good_frames);
    $display("bad-checksum and broken-sync traffic; %0d results checked, %0d errors",
             report_count, error_count + pending_count);
    if (error_count == 0 && pending_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result receiver: random stalls, steady stretches, and one long hold-off
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      if ($urandom_range(0, 255) == 0) sink_steady = !sink_steady;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results still due", cycle_count, pending_count);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/gbfp_pkg.sv
rtl/gbfp_frame_fsm.sv
rtl/gbfp_field_store.sv
rtl/gnss_binary_frame_parser.sv
test/frame_report_checker.sv
test/testbench.sv
